@@ sv/nci_pkg.sv @@
// Shared types and constants for the NMO correction and interpolation unit.
// Used by the top level, the front end and the back end; depends on nothing.
package nci_pkg;

  localparam int MaxSamples = 4096;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int SampleW    = 16;
  localparam int LenW       = AddrW + 1;
  localparam int TnW        = 45;   // time_origin + index * time_step
  localparam int AhW        = 43;   // |offset|
  localparam int QW         = 45;   // offset over velocity, Q29.16, below 2^45
  localparam int Q2W        = 90;

  typedef enum logic {
    CmdLoad    = 1'b0,
    CmdCompute = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    RegTimeOrigin   = 3'd0,
    RegTimeStep     = 3'd1,
    RegOffsetOrigin = 3'd2,
    RegOffsetStep   = 3'd3,
    RegMuteScale    = 3'd4,
    RegTraceLength  = 3'd5
  } reg_e;

  typedef struct packed {
    logic        [31:0]   time_origin;
    logic        [31:0]   time_step;
    logic signed [31:0]   offset_origin;
    logic signed [31:0]   offset_step;
    logic        [31:0]   mute_scale;
    logic        [LenW-1:0] trace_length;
  } cfg_t;

  typedef struct packed {
    cmd_e                      cmd;
    logic        [AddrW-1:0]   idx;
    logic signed [SampleW-1:0] value;
    logic        [31:0]        vel;
    logic        [TnW-1:0]     tn;
    logic        [AhW-1:0]     ah;
  } entry_t;

endpackage

@@ sv/nmo_correction_interp_unit.sv @@
// NMO correction unit: load a trace, then compute moveout-corrected samples.
// A load word is written when the back end takes it from the queue; a compute word
// runs two 64-step divides, three 12-step multiplies and a 62-step square root
// before its result strobes, fewer steps when muted early. One load per cycle while
// the back end is idle; a compute ends before the next word is taken. Busy when the
// two-word queue is full. Reset clears control, config and queue, not the store.
module nmo_correction_interp_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               command_i,
  input  logic [11:0]                        sample_index_i,
  input  logic signed [15:0]                 sample_value_i,
  input  logic [31:0]                        velocity_i,
  input  logic [9:0]                         offset_index_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [2:0]                         cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  output logic                               result_strobe_o,
  output logic signed [nci_pkg::SampleW-1:0] out_sample_o,
  output logic                               muted_o
);

  nci_pkg::cfg_t   cfg_q;
  nci_pkg::entry_t entry;
  logic            avail, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_origin   <= 32'd0;
      cfg_q.time_step     <= 32'd262;
      cfg_q.offset_origin <= 32'sd0;
      cfg_q.offset_step   <= 32'sd65536;
      cfg_q.mute_scale    <= 32'd52429;
      cfg_q.trace_length  <= nci_pkg::LenW'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (nci_pkg::reg_e'(cfg_index_i))
        nci_pkg::RegTimeOrigin:   cfg_q.time_origin   <= cfg_data_i;
        nci_pkg::RegTimeStep:     cfg_q.time_step     <= cfg_data_i;
        nci_pkg::RegOffsetOrigin: cfg_q.offset_origin <= cfg_data_i;
        nci_pkg::RegOffsetStep:   cfg_q.offset_step   <= cfg_data_i;
        nci_pkg::RegMuteScale:    cfg_q.mute_scale    <= cfg_data_i;
        nci_pkg::RegTraceLength:  cfg_q.trace_length  <= cfg_data_i[nci_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  nci_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .start, .busy,
    .command_i, .sample_index_i, .sample_value_i, .velocity_i, .offset_index_i,
    .avail_o(avail), .entry_o(entry), .pop_i(pop)
  );

  nci_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .avail_i(avail), .entry_i(entry),
    .pop_o(pop), .result_strobe_o, .out_sample_o, .muted_o
  );

endmodule

@@ sv/nci_front.sv @@
// Front end: accepts commands, forms zero-offset time and absolute offset,
// and queues the words for the back end. Depends on nci_pkg.
module nci_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nci_pkg::cfg_t               cfg_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [11:0]                 sample_index_i,
  input  logic signed [15:0]          sample_value_i,
  input  logic [31:0]                 velocity_i,
  input  logic [9:0]                  offset_index_i,
  output logic                        avail_o,
  output nci_pkg::entry_t             entry_o,
  input  logic                        pop_i
);

  nci_pkg::entry_t ent_q [2];
  nci_pkg::entry_t push_ent;
  logic            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  logic signed [43:0] h_org, h_stp, h_idx, h;
  logic [43:0]     tn_full;

  assign busy    = (cnt_q == 2'd2);
  assign push    = start && !busy;
  assign avail_o = (cnt_q != 2'd0);
  assign entry_o = ent_q[rd_ptr_q];

  always_comb begin
    h_org   = 44'(cfg_i.offset_origin);
    h_stp   = 44'(cfg_i.offset_step);
    h_idx   = $signed({34'b0, offset_index_i});
    h       = h_org + h_idx * h_stp;
    tn_full = 44'(sample_index_i) * 44'(cfg_i.time_step);
    push_ent.cmd   = nci_pkg::cmd_e'(command_i);
    push_ent.idx   = sample_index_i;
    push_ent.value = sample_value_i;
    push_ent.vel   = velocity_i;
    push_ent.tn    = 45'(tn_full) + 45'(cfg_i.time_origin);
    push_ent.ah    = h[43] ? 43'(-h) : 43'(h);
  end

  always_comb begin
    wr_ptr_d = push  ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_ent;
    end
  end

endmodule

@@ sv/nci_div.sv @@
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Depends on nothing.
module nci_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [31:0] rem_q, dvs_q;
  logic [63:0] quo_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [32:0] sh;
  logic [33:0] diff;

  assign sh     = {rem_q, quo_q[63]};
  assign diff   = {1'b0, sh} - {2'b0, dvs_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 32'd0;
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (run_q) begin
      // keep the difference only when it did not borrow
      rem_q <= diff[33] ? sh[31:0] : diff[31:0];
      quo_q <= {quo_q[62:0], !diff[33]};
    end
  end

endmodule

@@ sv/nci_mul.sv @@
// Radix-16 shift-add multiplier, 96 by 48 bits into a 128-bit product,
// one 4-bit digit of the second operand per cycle. Depends on nothing.
module nci_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [95:0]  a_i,
  input  logic [47:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [127:0] a_q, p_q, part;
  logic [47:0]  b_q;
  logic [3:0]   cnt_q;
  logic         run_q, done_q;

  assign part   = a_q * {124'b0, b_q[3:0]};
  assign done_o = done_q;
  assign prod_o = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 4'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd11) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= {32'b0, a_i};
      b_q <= b_i;
      p_q <= 128'd0;
    end else if (run_q) begin
      p_q <= p_q + part;
      a_q <= {a_q[123:0], 4'b0};
      b_q <= {4'b0, b_q[47:4]};
    end
  end

endmodule

@@ sv/nci_back.sv @@
// Back end: trace store, moveout sequencer (divide, multiply, square root,
// divide), stretch mute and linear interpolation. Depends on nci_pkg,
// nci_div and nci_mul.
module nci_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nci_pkg::cfg_t                      cfg_i,
  input  logic                               avail_i,
  input  nci_pkg::entry_t                    entry_i,
  output logic                               pop_o,
  output logic                               result_strobe_o,
  output logic signed [nci_pkg::SampleW-1:0] out_sample_o,
  output logic                               muted_o
);

  typedef enum logic [11:0] {
    StIdle   = 12'b0000_0000_0001,
    StDivQ   = 12'b0000_0000_0010,
    StMulQq  = 12'b0000_0000_0100,
    StMulTt  = 12'b0000_0000_1000,
    StMulMs  = 12'b0000_0001_0000,
    StSqrt   = 12'b0000_0010_0000,
    StSub    = 12'b0000_0100_0000,
    StDivT   = 12'b0000_1000_0000,
    StRdA    = 12'b0001_0000_0000,
    StRdB    = 12'b0010_0000_0000,
    StInterp = 12'b0100_0000_0000,
    StSpare  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic signed [nci_pkg::SampleW-1:0] mem [nci_pkg::MaxSamples];
  logic signed [nci_pkg::SampleW-1:0] rdata_q, a_q;
  logic [nci_pkg::AddrW-1:0]          rd_addr, iti_q;
  logic [15:0]                        fr_q;
  nci_pkg::entry_t                    ent_q;
  logic [nci_pkg::Q2W-1:0]            q2_q, t2_q;
  logic [123:0]                       x_q;
  logic [61:0]                        root_q;
  logic [63:0]                        rem_q;
  logic [5:0]                         cnt_q;
  logic                               strobe_q, muted_q;
  logic signed [nci_pkg::SampleW-1:0] out_q;

  logic         div_go, div_done, mul_go, mul_done;
  logic [63:0]  dvd, div_quo;
  logic [31:0]  dvs;
  logic [95:0]  mul_a;
  logic [47:0]  mul_b;
  logic [127:0] prod;
  logic         fin, fin_mute, mem_we, sqrt_init;

  logic [65:0]  rem_sh, trial;
  logic         ge;
  logic [63:0]  ot32, rel_time;
  logic [nci_pkg::LenW-1:0] len;
  logic         out_range;
  logic [90:0]  tq_sum;

  logic signed [16:0] delta;
  logic signed [34:0] acc;
  logic signed [34:0] shr;
  logic signed [nci_pkg::SampleW-1:0] interp;

  nci_div u_div (
    .clk_i, .rst_ni, .start_i(div_go), .dvd_i(dvd), .dvs_i(dvs),
    .done_o(div_done), .quo_o(div_quo)
  );

  nci_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(prod)
  );

  // one digit pair of the square root per cycle
  assign rem_sh = {rem_q, x_q[123:122]};
  assign trial  = {2'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign tq_sum = {1'b0, t2_q} + {1'b0, q2_q};

  assign ot32     = {cfg_i.time_origin, 32'b0};
  assign rel_time = ({2'b0, root_q} > ot32) ? ({2'b0, root_q} - ot32) : 64'd0;

  assign len = (cfg_i.trace_length > nci_pkg::LenW'(nci_pkg::MaxSamples))
             ? nci_pkg::LenW'(nci_pkg::MaxSamples) : cfg_i.trace_length;
  assign out_range = (len < nci_pkg::LenW'(2)) ||
                     (div_quo[63:16] >= 48'(len - nci_pkg::LenW'(1)));

  // a*(1-f) + b*f written as a + (b-a)*f, then truncated toward zero
  always_comb begin
    delta  = 17'(rdata_q) - 17'(a_q);
    acc    = {{3{a_q[15]}}, a_q, 16'b0} + 35'(delta * $signed({1'b0, fr_q}));
    shr    = acc >>> 16;
    interp = (acc[34] && (acc[15:0] != 16'd0)) ? 16'(shr + 35'sd1) : 16'(shr);
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_go    = 1'b0;
    dvd       = {5'b0, entry_i.ah, 16'b0};
    dvs       = entry_i.vel;
    mul_go    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    fin       = 1'b0;
    fin_mute  = 1'b0;
    mem_we    = 1'b0;
    sqrt_init = 1'b0;
    rd_addr   = iti_q;
    unique case (state_q)
      StIdle: begin
        if (avail_i) begin
          pop_o = 1'b1;
          if (entry_i.cmd == nci_pkg::CmdLoad) begin
            mem_we = 1'b1;
          end else if (cfg_i.time_step == 32'd0 || entry_i.vel == 32'd0) begin
            fin      = 1'b1;
            fin_mute = 1'b1;
          end else begin
            div_go  = 1'b1;
            state_d = StDivQ;
          end
        end
      end
      StDivQ: begin
        if (div_done) begin
          if (div_quo[63:nci_pkg::QW] != '0) begin
            fin      = 1'b1;
            fin_mute = 1'b1;
            state_d  = StIdle;
          end else begin
            mul_go  = 1'b1;
            mul_a   = 96'(div_quo[nci_pkg::QW-1:0]);
            mul_b   = 48'(div_quo[nci_pkg::QW-1:0]);
            state_d = StMulQq;
          end
        end
      end
      StMulQq: begin
        if (mul_done) begin
          mul_go  = 1'b1;
          mul_a   = 96'(ent_q.tn);
          mul_b   = 48'(ent_q.tn);
          state_d = StMulTt;
        end
      end
      StMulTt: begin
        if (mul_done) begin
          mul_go  = 1'b1;
          mul_a   = 96'(q2_q);
          mul_b   = 48'(cfg_i.mute_scale);
          state_d = StMulMs;
        end
      end
      StMulMs: begin
        if (mul_done) begin
          if (prod >= {22'b0, t2_q, 16'b0}) begin
            fin      = 1'b1;
            fin_mute = 1'b1;
            state_d  = StIdle;
          end else begin
            sqrt_init = 1'b1;
            state_d   = StSqrt;
          end
        end
      end
      StSqrt: begin
        if (cnt_q == 6'd61) begin
          state_d = StSub;
        end
      end
      StSub: begin
        div_go  = 1'b1;
        dvd     = rel_time;
        dvs     = cfg_i.time_step;
        state_d = StDivT;
      end
      StDivT: begin
        if (div_done) begin
          if (out_range) begin
            fin      = 1'b1;
            fin_mute = 1'b1;
            state_d  = StIdle;
          end else begin
            state_d = StRdA;
          end
        end
      end
      StRdA: begin
        state_d = StRdB;
      end
      StRdB: begin
        rd_addr = iti_q + nci_pkg::AddrW'(1);
        state_d = StInterp;
      end
      StInterp: begin
        fin     = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry_i.idx] <= entry_i.value;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
    if (state_q == StMulQq && mul_done) begin
      q2_q <= prod[nci_pkg::Q2W-1:0];
    end
    if (state_q == StMulTt && mul_done) begin
      t2_q <= prod[nci_pkg::Q2W-1:0];
    end
    if (sqrt_init) begin
      x_q    <= {1'b0, tq_sum, 32'b0};
      root_q <= 62'd0;
      rem_q  <= 64'd0;
      cnt_q  <= 6'd0;
    end else if (state_q == StSqrt) begin
      x_q    <= {x_q[121:0], 2'b0};
      root_q <= {root_q[60:0], ge};
      rem_q  <= ge ? 64'(rem_sh - trial) : rem_sh[63:0];
      cnt_q  <= cnt_q + 6'd1;
    end
    if (state_q == StDivT && div_done) begin
      iti_q <= div_quo[16 +: nci_pkg::AddrW];
      fr_q  <= div_quo[15:0];
    end
    if (state_q == StRdB) begin
      a_q <= rdata_q;
    end
    if (fin) begin
      out_q   <= fin_mute ? '0 : interp;
      muted_q <= fin_mute;
    end
  end

  assign result_strobe_o = strobe_q;
  assign out_sample_o    = out_q;
  assign muted_o         = muted_q;

endmodule

@@ sv/nci_checker.sv @@
// Port-level checks for the NMO correction unit, bound to the top level.
// Depends on nmo_correction_interp_unit.
module nci_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        result_strobe_o,
  input logic [15:0] out_sample_o,
  input logic        muted_o
);

  a_mute_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && muted_o |-> out_sample_o == 16'd0)
    else $error("muted result carries a nonzero sample");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !busy && !result_strobe_o)
    else $error("activity right after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind nmo_correction_interp_unit nci_checker u_nci_checker (
  .clk_i, .rst_ni, .busy, .cfg_valid_i, .cfg_ready_o,
  .result_strobe_o, .out_sample_o, .muted_o
);

@@ tb/tb_nmo_correction_interp_unit.sv @@
// Testbench for nmo_correction_interp_unit: directed and random load/compute words,
// checked against an in-bench moveout predictor. Depends on nci_pkg and the RTL.
module tb_nmo_correction_interp_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 300;
  localparam int WatchLimit  = 20000;
  localparam int FillDepth   = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic command_i = 1'b0;
  logic [11:0] sample_index_i = '0;
  logic signed [15:0] sample_value_i = '0;
  logic [31:0] velocity_i = '0;
  logic [9:0] offset_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic result_strobe_o;
  logic signed [nci_pkg::SampleW-1:0] out_sample_o;
  logic muted_o;

  nmo_correction_interp_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct {
    logic signed [15:0] sample;
    logic               muted;
  } moveout_t;

  moveout_t            moveout_q[$];
  logic signed [15:0]  trace_mem[nci_pkg::MaxSamples];
  logic [31:0]         m_time_origin, m_time_step, m_offset_origin, m_offset_step;
  logic [31:0]         m_mute_scale;
  logic [12:0]         m_trace_length;
  int                  errors = 0;
  int                  gap_pct = 0;
  int                  n_loads = 0, n_computes = 0, n_muted = 0, n_results = 0;
  int                  idle_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int b = 61; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq = {64'd0, cand} * {64'd0, cand};
      if (!(x < sq)) r = cand;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs_offset(input logic [9:0] oidx);
    longint h;
    h = longint'($signed(m_offset_origin)) + longint'({54'd0, oidx}) *
        longint'($signed(m_offset_step));
    return (h < 0) ? 64'(-h) : 64'(h);
  endfunction

  // Moveout time, position and interpolation for one compute word.
  function automatic moveout_t predict_moveout(input logic [11:0] idx, input logic [31:0] vel,
                                               input logic [9:0] oidx);
    moveout_t     r;
    logic [63:0]  tn, ah, q, s, ot32, d, ti, iti, fr, len;
    logic [127:0] q2, t2, lhs;
    longint       a, b;
    r.sample = '0;
    r.muted = 1'b1;
    if (m_time_step == 0 || vel == 0) return r;
    tn = {32'd0, m_time_origin} + {52'd0, idx} * {32'd0, m_time_step};
    ah = abs_offset(oidx);
    q = (ah << 16) / {32'd0, vel};
    if (q >= (64'd1 << 45)) return r;
    q2 = {64'd0, q} * {64'd0, q};
    t2 = {64'd0, tn} * {64'd0, tn};
    lhs = q2 * {96'd0, m_mute_scale};
    if (!(lhs < (t2 << 16))) return r;
    s = isqrt((t2 + q2) << 32);
    ot32 = {m_time_origin, 32'd0};
    d = (s > ot32) ? s - ot32 : 64'd0;
    ti = d / {32'd0, m_time_step};
    iti = ti >> 16;
    fr = ti & 64'hFFFF;
    len = (m_trace_length > nci_pkg::MaxSamples) ? 64'(nci_pkg::MaxSamples)
                                                  : {51'd0, m_trace_length};
    if (len < 2 || iti >= len - 1) return r;
    a = longint'(trace_mem[iti]);
    b = longint'(trace_mem[iti + 1]);
    r.sample = 16'((a * (65536 - longint'(fr)) + b * longint'(fr)) / 65536);
    r.muted = 1'b0;
    return r;
  endfunction

  // Leaves start high so back-to-back words need no second assignment.
  task automatic send_word(input nci_pkg::cmd_e cmd, input logic [11:0] idx,
                           input logic [15:0] val, input logic [31:0] vel,
                           input logic [9:0] oidx);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    sample_index_i <= idx;
    sample_value_i <= val;
    velocity_i <= vel;
    offset_index_i <= oidx;
    do @(posedge clk_i); while (busy);
    if (cmd == nci_pkg::CmdLoad) begin
      trace_mem[idx] = val;
      n_loads++;
    end else begin
      moveout_q.push_back(predict_moveout(idx, vel, oidx));
      n_computes++;
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    wait (moveout_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input nci_pkg::reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      nci_pkg::RegTimeOrigin:   m_time_origin = data;
      nci_pkg::RegTimeStep:     m_time_step = data;
      nci_pkg::RegOffsetOrigin: m_offset_origin = data;
      nci_pkg::RegOffsetStep:   m_offset_step = data;
      nci_pkg::RegMuteScale:    m_mute_scale = data;
      nci_pkg::RegTraceLength:  m_trace_length = data[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] t0, ts, o0, os, ms, len);
    drain();
    write_reg(nci_pkg::RegTimeOrigin, t0);
    write_reg(nci_pkg::RegTimeStep, ts);
    write_reg(nci_pkg::RegOffsetOrigin, o0);
    write_reg(nci_pkg::RegOffsetStep, os);
    write_reg(nci_pkg::RegMuteScale, ms);
    write_reg(nci_pkg::RegTraceLength, len);
    cfg_valid_i <= 1'b0;
  endtask

  // Write the low store entries; random settings other than the 4096-sample one keep their trace length inside them.
  task automatic test_fill_trace;
    for (int i = 0; i < FillDepth; i++) begin
      send_word(nci_pkg::CmdLoad, 12'(i), 16'($urandom), '0, '0);
    end
  endtask

  task automatic test_field_extremes;
    send_word(nci_pkg::CmdLoad, 12'd0, 16'sh8000, 32'hFFFFFFFF, 10'h3FF);
    send_word(nci_pkg::CmdLoad, 12'd1, 16'sh7FFF, '0, '0);
    send_word(nci_pkg::CmdLoad, 12'hFFE, 16'sh8001, '0, '0);
    send_word(nci_pkg::CmdLoad, 12'hFFF, 16'sh7FFF, '0, '0);
    send_word(nci_pkg::CmdCompute, 12'd0, '0, 32'hFFFFFFFF, 10'd0);
    send_word(nci_pkg::CmdCompute, 12'd1, '0, 32'd65536, 10'd1);
    send_word(nci_pkg::CmdCompute, 12'hFFF, 16'hFFFF, 32'd1, 10'h3FF);
    send_word(nci_pkg::CmdCompute, 12'd500, '0, 32'd1, 10'h3FF);
    send_word(nci_pkg::CmdCompute, 12'd500, '0, 32'd0, 10'd5);          // zero velocity
    send_word(nci_pkg::CmdCompute, 12'd1023, '0, 32'h000A0000, 10'd0);  // last sample edge
    send_word(nci_pkg::CmdCompute, 12'd2000, '0, 32'h000A0000, 10'd3);  // index past length
    send_word(nci_pkg::CmdCompute, 12'd300, '0, 32'h00010000, 10'd2);
  endtask

  task automatic test_special_cases;
    // huge offset over velocity
    set_config(32'd0, 32'd262, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd52429, 32'd1024);
    send_word(nci_pkg::CmdCompute, 12'd100, '0, 32'd1, 10'h3FF);
    send_word(nci_pkg::CmdCompute, 12'd100, '0, 32'hFFFFFFFF, 10'd0);
    // zero time step, length below two
    set_config(32'd0, 32'd0, 32'd0, 32'd65536, 32'd52429, 32'd1);
    send_word(nci_pkg::CmdCompute, 12'd10, '0, 32'd65536, 10'd1);
    set_config(32'd0, 32'd262, 32'd0, 32'd65536, 32'd52429, 32'd1);
    send_word(nci_pkg::CmdCompute, 12'd0, '0, 32'hFFFFFFFF, 10'd0);
    // length beyond the store
    set_config(32'd0, 32'd262, 32'd0, 32'd65536, 32'd52429, 32'h1FFF);
    send_word(nci_pkg::CmdCompute, 12'd4094, '0, 32'hFFFFFFFF, 10'd0);
    send_word(nci_pkg::CmdCompute, 12'd4095, '0, 32'hFFFFFFFF, 10'd0);
  endtask

  task automatic test_random_phase(input int count, input int gap);
    logic [11:0] idx;
    logic [9:0]  oidx;
    logic [63:0] ah, v;
    int          len;
    gap_pct = gap;
    len = (m_trace_length > nci_pkg::MaxSamples) ? nci_pkg::MaxSamples : m_trace_length;
    if (len < 1) len = 1;
    for (int n = 0; n < count; n++) begin
      oidx = 10'($urandom);
      if ($urandom_range(99) < 25) begin
        send_word(nci_pkg::CmdLoad, 12'($urandom), 16'($urandom), $urandom, oidx);
      end else if ($urandom_range(99) < 75) begin
        // well-formed: index inside the trace, velocity between 1/16 and 4 times the offset
        idx = 12'($urandom_range(len - 1));
        ah = abs_offset(oidx);
        v = (ah * 64'($urandom_range(1, 64))) >> 4;
        if (v == 0) v = 64'($urandom_range(1, 1 << 20));
        if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
        send_word(nci_pkg::CmdCompute, idx, 16'($urandom), v[31:0], oidx);
      end else begin
        send_word(nci_pkg::CmdCompute, 12'($urandom), 16'($urandom),
                  ($urandom_range(9) == 0) ? 32'd0 : $urandom, oidx);
      end
    end
  endtask

  always @(posedge clk_i) begin
    moveout_t w;
    if (rst_ni && result_strobe_o) begin
      n_results++;
      if (moveout_q.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        w = moveout_q.pop_front();
        if (w.muted) n_muted++;
        if (out_sample_o !== w.sample) report_mismatch("out_sample", out_sample_o, w.sample);
        if (muted_o !== w.muted) report_mismatch("muted", muted_o, w.muted);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    m_time_origin = 32'd0;
    m_time_step = 32'd262;
    m_offset_origin = 32'd0;
    m_offset_step = 32'd65536;
    m_mute_scale = 32'd52429;
    m_trace_length = 13'd1024;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_trace();
    test_field_extremes();
    test_special_cases();
    set_config(32'd0, 32'd262, 32'd0, 32'd65536, 32'd52429, 32'd256);
    test_random_phase(250, 0);
    set_config(32'd100000, 32'd655, 32'hFFF60000, 32'd32768, 32'd21845, 32'd256);
    test_random_phase(200, 67);
    set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd4096);
    test_random_phase(100, 38);
    set_config(32'd0, 32'd1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd2);
    test_random_phase(100, 38);
    set_config(32'd6553, 32'd131, 32'd0, 32'h00020000, 32'd65536, 32'd256);
    test_random_phase(280, 38);
    drain();
    $display("Covered %0d loads and %0d computes (%0d muted) over edge-case and",
             n_loads, n_computes, n_muted);
    $display("five random register settings, sender gaps 0/38/67 percent; %0d results checked",
             n_results);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
